// ----- rtl/sdl_pkg.sv -----
// ----------------------------------------------------------------------------
// Spring-damper link package
// Shared field widths, item kinds and register indexes for the link force block.
// ----------------------------------------------------------------------------
package sdl_pkg;

   // Payload and register widths.
   localparam int unsigned DATA_W = 32;
   localparam int unsigned LEN_W  = 31;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned ADDR_W = 5;

   // Default upper distance limit in whole length units, before scaling.
   localparam int unsigned LENGTH_LIMIT_UNITS = 10000;

   // Item kinds carried by each input beat.
   localparam logic [KIND_W-1:0] KIND_STEP  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_KEEP  = 2'd2;

   // Register indexes, one 32-bit word each.
   localparam logic [2:0] REG_STIFFNESS    = 3'd0;
   localparam logic [2:0] REG_LINK_DAMPING = 3'd1;
   localparam logic [2:0] REG_MASS_DAMPING = 3'd2;
   localparam logic [2:0] REG_REST_LENGTH  = 3'd3;
   localparam logic [2:0] REG_MIN_LENGTH   = 3'd4;
   localparam logic [2:0] REG_MAX_LENGTH   = 3'd5;

endpackage

// ----- rtl/sdl_req_if.sv -----
// ----------------------------------------------------------------------------
// Spring-damper link request channel
// Carries one item kind and two mass positions per beat.
// ----------------------------------------------------------------------------
interface sdl_req_if
   import sdl_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] position_a;
   logic signed [DATA_W-1:0] position_b;

   modport source (output valid, kind, position_a, position_b, input ready);
   modport sink   (input valid, kind, position_a, position_b, output ready);

endinterface

// ----- rtl/sdl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Spring-damper link response channel
// Carries the two saturated mass forces per beat.
// ----------------------------------------------------------------------------
interface sdl_rsp_if
   import sdl_pkg::*;
   ();

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] force_a;
   logic signed [DATA_W-1:0] force_b;

   modport source (output valid, force_a, force_b, input ready);
   modport sink   (input valid, force_a, force_b, output ready);

endinterface

// ----- rtl/spring_damper_link_force_top.sv -----
// ----------------------------------------------------------------------------
// Spring-damper link force
// One-axis link between two masses in fixed point, one beat per cycle while rsp_beat is not held off.
// ----------------------------------------------------------------------------
// Usage:
//   req_beat carries a kind and two positions. A step beat yields one beat on
//   rsp_beat with the forces on both masses; the two reset kinds only reload
//   the stored history and yield no beat. Unused kind codes are dropped.
//   The csr_ port holds the spring and damping constants and the distance
//   window; write it only while no beat is in flight.
// Pipeline and throughput:
//   A step beat passes the input, distance, deltas, multipliers, link force
//   and output registers in order. The block takes one beat per cycle while
//   rsp_beat is not held off; in the six-register pipe every stage moves on
//   whenever the stage after it is empty or moving.
// Reset:
//   reset is synchronous; it restores register defaults and clears the history
//   and all stage valid bits.
// Stalls:
//   While rsp_beat is held off, earlier stages keep filling their empty slots,
//   so up to six beats are held before req_beat.ready drops.
// ----------------------------------------------------------------------------
module spring_damper_link_force_top
   import sdl_pkg::*;
   #(
      parameter int unsigned FRAC_BITS = 16
   ) (
      input  logic              clock,
      input  logic              reset,
      sdl_req_if.sink           req_beat,
      sdl_rsp_if.source         rsp_beat,
      input  logic              csr_psel,
      input  logic              csr_penable,
      input  logic              csr_pwrite,
      input  logic [ADDR_W-1:0] csr_paddr,
      input  logic [DATA_W-1:0] csr_pwdata,
      output logic [DATA_W-1:0] csr_prdata,
      output logic              csr_pready
   );

   // Product and shifted product widths.
   localparam int unsigned DIFF_W = DATA_W + 1;
   localparam int unsigned PROD_W = DIFF_W + DATA_W;
   localparam int unsigned SH_W   = PROD_W - FRAC_BITS;
   localparam int unsigned SUM_W  = SH_W + 1;

   // Default maximum length, clipped to the 31-bit range.
   localparam logic [63:0] MAX_WIDE  = 64'(LENGTH_LIMIT_UNITS) << FRAC_BITS;
   localparam logic [LEN_W-1:0] MAX_RESET =
      (MAX_WIDE > 64'h7FFF_FFFF) ? {LEN_W{1'b1}} : MAX_WIDE[LEN_W-1:0];

   localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Saturate a wide signed sum to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat_to_32(
      input logic signed [SUM_W-1:0] x
   );
      logic [SUM_W-DATA_W:0] hi;
      hi = x[SUM_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         return x[DATA_W-1:0];
      end
      return x[SUM_W-1] ? S32_MIN : S32_MAX;
   endfunction

   // Configuration registers.
   logic signed [DATA_W-1:0] stiffness_ff, link_damping_ff, mass_damping_ff;
   logic signed [DATA_W-1:0] rest_length_ff;
   logic [LEN_W-1:0]         min_length_ff, max_length_ff;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff    <= '0;
         link_damping_ff <= '0;
         mass_damping_ff <= '0;
         rest_length_ff  <= '0;
         min_length_ff   <= '0;
         max_length_ff   <= MAX_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_STIFFNESS:    stiffness_ff    <= csr_pwdata;
            REG_LINK_DAMPING: link_damping_ff <= csr_pwdata;
            REG_MASS_DAMPING: mass_damping_ff <= csr_pwdata;
            REG_REST_LENGTH:  rest_length_ff  <= csr_pwdata;
            REG_MIN_LENGTH:   min_length_ff   <= csr_pwdata[LEN_W-1:0];
            REG_MAX_LENGTH:   max_length_ff   <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_STIFFNESS:    csr_prdata = stiffness_ff;
         REG_LINK_DAMPING: csr_prdata = link_damping_ff;
         REG_MASS_DAMPING: csr_prdata = mass_damping_ff;
         REG_REST_LENGTH:  csr_prdata = rest_length_ff;
         REG_MIN_LENGTH:   csr_prdata = {1'b0, min_length_ff};
         REG_MAX_LENGTH:   csr_prdata = {1'b0, max_length_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Stage valid bits and advance enables; a stage loads when it is empty
   // or its contents move on in the same cycle.
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic out_valid_ff;
   logic en0, en1, en2, en3, en4, en_out;

   assign en_out = !out_valid_ff || rsp_beat.ready;
   assign en4    = !s4_valid_ff || en_out;
   assign en3    = !s3_valid_ff || en4;
   assign en2    = !s2_valid_ff || en3;
   assign en1    = !s1_valid_ff || en2;
   assign en0    = !s0_valid_ff || en1;

   assign req_beat.ready = en0;

   // Input register.
   logic [KIND_W-1:0]        s0_kind_ff;
   logic signed [DATA_W-1:0] s0_pa_ff, s0_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en0) begin
         s0_valid_ff <= req_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         s0_kind_ff <= req_beat.kind;
         s0_pa_ff   <= req_beat.position_a;
         s0_pb_ff   <= req_beat.position_b;
      end
   end

   // Stage 1: distance, direction and own-motion deltas of both masses.
   logic signed [DIFF_W-1:0] diff, mag;
   logic [LEN_W-1:0]         distance;
   logic signed [DATA_W-1:0] prev_pa_ff, prev_pb_ff, prev_pa_in, prev_pb_in;
   logic signed [DIFF_W-1:0] da, db;
   logic                     s1_load, s1_keep;

   assign diff     = DIFF_W'(s0_pb_ff) - DIFF_W'(s0_pa_ff);
   assign mag      = diff[DIFF_W-1] ? -diff : diff;
   assign distance = mag[DATA_W-1] ? {LEN_W{1'b1}} : mag[LEN_W-1:0];
   assign da       = DIFF_W'(prev_pa_ff) - DIFF_W'(s0_pa_ff);
   assign db       = DIFF_W'(prev_pb_ff) - DIFF_W'(s0_pb_ff);

   // Unused kind codes are dropped here without touching the history.
   assign s1_keep = (s0_kind_ff == KIND_STEP) || (s0_kind_ff == KIND_RESET) ||
                    (s0_kind_ff == KIND_KEEP);
   assign s1_load = en1 && s0_valid_ff && s1_keep;

   always_comb begin
      prev_pa_in = prev_pa_ff;
      prev_pb_in = prev_pb_ff;
      if (s1_load) begin
         if (s0_kind_ff == KIND_RESET) begin
            prev_pa_in = '0;
            prev_pb_in = '0;
         end else begin
            prev_pa_in = s0_pa_ff;
            prev_pb_in = s0_pb_ff;
         end
      end
   end

   logic [KIND_W-1:0]        s1_kind_ff;
   logic [LEN_W-1:0]         s1_dist_ff;
   logic                     s1_neg_ff;
   logic signed [DIFF_W-1:0] s1_da_ff, s1_db_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prev_pa_ff  <= '0;
         prev_pb_ff  <= '0;
      end else begin
         if (en1) begin
            s1_valid_ff <= s0_valid_ff && s1_keep;
         end
         prev_pa_ff <= prev_pa_in;
         prev_pb_ff <= prev_pb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_kind_ff <= s0_kind_ff;
         s1_dist_ff <= distance;
         s1_neg_ff  <= diff[DIFF_W-1];
         s1_da_ff   <= da;
         s1_db_ff   <= db;
      end
   end

   // Stage 2: stretch, change of distance and the distance window.
   logic signed [DATA_W-1:0] prev_dist_ff, prev_dist_in;
   logic signed [DIFF_W-1:0] dd_rest, dd_link;
   logic                     gate, s1_step;

   assign s1_step = s1_kind_ff == KIND_STEP;
   assign dd_rest = DIFF_W'({1'b0, s1_dist_ff}) - DIFF_W'(rest_length_ff);
   assign dd_link = DIFF_W'({1'b0, s1_dist_ff}) - DIFF_W'(prev_dist_ff);
   assign gate    = (s1_dist_ff > max_length_ff) || (s1_dist_ff < min_length_ff);

   // Distance history: both reset kinds load the rest length.
   always_comb begin
      prev_dist_in = prev_dist_ff;
      if (en2 && s1_valid_ff) begin
         prev_dist_in = s1_step ? DATA_W'({1'b0, s1_dist_ff}) : rest_length_ff;
      end
   end

   logic signed [DIFF_W-1:0] s2_dd_rest_ff, s2_dd_link_ff, s2_da_ff, s2_db_ff;
   logic                     s2_gate_ff, s2_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         prev_dist_ff <= '0;
      end else begin
         if (en2) begin
            s2_valid_ff <= s1_valid_ff && s1_step;
         end
         prev_dist_ff <= prev_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_dd_rest_ff <= dd_rest;
         s2_dd_link_ff <= dd_link;
         s2_da_ff      <= s1_da_ff;
         s2_db_ff      <= s1_db_ff;
         s2_gate_ff    <= gate;
         s2_neg_ff     <= s1_neg_ff;
      end
   end

   // Stage 3: four products; dropping the fraction bits rounds toward minus
   // infinity.
   logic signed [PROD_W-1:0] prod_k, prod_l, prod_a, prod_b;

   assign prod_k = PROD_W'(s2_dd_rest_ff) * PROD_W'(stiffness_ff);
   assign prod_l = PROD_W'(s2_dd_link_ff) * PROD_W'(link_damping_ff);
   assign prod_a = PROD_W'(s2_da_ff) * PROD_W'(mass_damping_ff);
   assign prod_b = PROD_W'(s2_db_ff) * PROD_W'(mass_damping_ff);

   logic signed [SH_W-1:0] s3_pk_ff, s3_pl_ff, s3_pa_ff, s3_pb_ff;
   logic                   s3_gate_ff, s3_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_pk_ff   <= prod_k[PROD_W-1:FRAC_BITS];
         s3_pl_ff   <= prod_l[PROD_W-1:FRAC_BITS];
         s3_pa_ff   <= prod_a[PROD_W-1:FRAC_BITS];
         s3_pb_ff   <= prod_b[PROD_W-1:FRAC_BITS];
         s3_gate_ff <= s2_gate_ff;
         s3_neg_ff  <= s2_neg_ff;
      end
   end

   // Stage 4: link force, saturated, gated by the window, then signed by the
   // direction between the masses.
   logic signed [SUM_W-1:0]  link_sum;
   logic signed [DATA_W-1:0] link_sat, link_gated, link_dir;

   assign link_sum   = SUM_W'(s3_pk_ff) + SUM_W'(s3_pl_ff);
   assign link_sat   = sat_to_32(link_sum);
   assign link_gated = s3_gate_ff ? '0 : link_sat;

   always_comb begin
      link_dir = link_gated;
      if (s3_neg_ff) begin
         link_dir = (link_gated == S32_MIN) ? S32_MAX : -link_gated;
      end
   end

   logic signed [DATA_W-1:0] s4_link_ff;
   logic signed [SH_W-1:0]   s4_pa_ff, s4_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_link_ff <= link_dir;
         s4_pa_ff   <= s3_pa_ff;
         s4_pb_ff   <= s3_pb_ff;
      end
   end

   // Output register: each mass force adds its own damping term.
   logic signed [SUM_W-1:0]  sum_a, sum_b;
   logic signed [DATA_W-1:0] force_a_ff, force_b_ff;

   assign sum_a = SUM_W'(s4_pa_ff) + SUM_W'(s4_link_ff);
   assign sum_b = SUM_W'(s4_pb_ff) - SUM_W'(s4_link_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         force_a_ff <= sat_to_32(sum_a);
         force_b_ff <= sat_to_32(sum_b);
      end
   end

   assign rsp_beat.valid   = out_valid_ff;
   assign rsp_beat.force_a = force_a_ff;
   assign rsp_beat.force_b = force_b_ff;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spring-damper link force testbench
// Drives position beats and register writes into the link force block and
// checks every force beat against a cycle-free model of the link arithmetic.
// A short scripted sequence covers the corner cases, then randomized phases
// under fresh register settings run with random idling and one long
// back-pressure stretch on the force channel.
// ----------------------------------------------------------------------------
module tb;
   import sdl_pkg::*;

   localparam int unsigned FRAC_BITS = 16;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam longint SAT_MAX = 64'sd2147483647;
   localparam longint SAT_MIN = -64'sd2147483648;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 101;
   localparam int RANDOM_PHASES = 6;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type        op;
      logic [KIND_W-1:0] kind;
      logic [2:0]        reg_idx;
      logic [31:0]       a;
      logic [31:0]       b;
      bit                typed;
      logic [31:0]       force_a;
      logic [31:0]       force_b;
   } script_row_type;

   typedef struct {
      logic [31:0] force_a;
      logic [31:0] force_b;
   } force_pair_type;

   typedef struct {
      logic [2:0]  idx;
      logic [31:0] value;
   } reg_write_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   sdl_req_if req_bus ();
   sdl_rsp_if rsp_bus ();

   spring_damper_link_force_top #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_bus),
      .rsp_beat    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model copy of the registers and of the stored history.
   logic [31:0] cfg_stiffness;
   logic [31:0] cfg_link_damping;
   logic [31:0] cfg_mass_damping;
   logic [31:0] cfg_rest_length;
   logic [30:0] cfg_min_length;
   logic [30:0] cfg_max_length;
   longint      last_distance;
   longint      last_position_a;
   longint      last_position_b;

   force_pair_type pending_forces[$];
   script_row_type script[$];
   reg_write_type  reg_batch[$];

   int  errors;
   int  beats_checked;
   int  n_step, n_reset, n_keep, n_unused, n_settings;
   int  cycle_count;
   bit  steady;
   bit  hold_off_req;
   logic [31:0] walk_a, walk_b;
   force_pair_type due;

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Q16.16 product, floored back to Q16.16.
   function automatic longint qmul_floor(input longint x, input longint y);
      return (x * y) >>> FRAC_BITS;
   endfunction

   function automatic longint sat32(input longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v;
   endfunction

   // Applies one accepted beat to the model history and returns the forces.
   function automatic bit advance_link(input logic [KIND_W-1:0] kind,
                                       input logic [31:0] pos_a, input logic [31:0] pos_b,
                                       output force_pair_type forces);
      longint pa, pb, diff, distance, link, fa, fb;
      pa = longint'($signed(pos_a));
      pb = longint'($signed(pos_b));
      forces.force_a = '0;
      forces.force_b = '0;
      case (kind)
         KIND_RESET: begin
            last_position_a = 0;
            last_position_b = 0;
            last_distance = longint'($signed(cfg_rest_length));
            return 1'b0;
         end
         KIND_KEEP: begin
            last_position_a = pa;
            last_position_b = pb;
            last_distance = longint'($signed(cfg_rest_length));
            return 1'b0;
         end
         KIND_STEP: ;
         default: return 1'b0;
      endcase

      // Distance, saturated to the positive 32-bit range.
      diff = pb - pa;
      distance = (diff < 0) ? -diff : diff;
      if (distance > SAT_MAX) distance = SAT_MAX;

      link = sat32(qmul_floor(longint'($signed(cfg_stiffness)),
                              distance - longint'($signed(cfg_rest_length))) +
                   qmul_floor(longint'($signed(cfg_link_damping)),
                              distance - last_distance));
      last_distance = distance;

      // Gate outside the window, then point the force from a toward b.
      if (distance > longint'(cfg_max_length) || distance < longint'(cfg_min_length))
         link = 0;
      if (diff < 0) link = sat32(-link);

      fb = sat32(-link + qmul_floor(last_position_b - pb,
                                    longint'($signed(cfg_mass_damping))));
      fa = sat32(link + qmul_floor(last_position_a - pa,
                                   longint'($signed(cfg_mass_damping))));
      last_position_a = pa;
      last_position_b = pb;
      forces.force_a = fa[31:0];
      forces.force_b = fb[31:0];
      return 1'b1;
   endfunction

   // Sender gap: mostly back to back, a few long pauses.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88) return KIND_STEP;
      if (r < 92) return KIND_RESET;
      if (r < 97) return KIND_KEEP;
      return KIND_UNUSED;
   endfunction

   // Mostly a slow walk so mass damping sees small motions; sometimes anything.
   function automatic logic [31:0] next_position(inout logic [31:0] walk);
      case ($urandom_range(0, 19)) inside
         0:       walk = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         [1:2]:   walk = $urandom;
         [3:7]:   walk = $urandom_range(0, 1000 << 16) - (500 << 16);
         default: walk = walk + $urandom_range(0, 16 << 16) - (8 << 16);
      endcase
      return walk;
   endfunction

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return $urandom_range(0, 1 << 19) - (1 << 18);
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_item(input logic [KIND_W-1:0] kind,
                                    input logic [31:0] a, input logic [31:0] b);
      script_row_type row;
      row = '{ROW_ITEM, kind, 3'd0, a, b, 1'b0, 32'h0, 32'h0};
      script.push_back(row);
   endfunction

   function automatic void add_typed(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] fa, input logic [31:0] fb);
      script_row_type row;
      row = '{ROW_ITEM, KIND_STEP, 3'd0, a, b, 1'b1, fa, fb};
      script.push_back(row);
   endfunction

   function automatic void add_csr(input logic [2:0] idx, input logic [31:0] value);
      script_row_type row;
      row = '{ROW_CSR, KIND_STEP, idx, value, 32'h0, 1'b0, 32'h0, 32'h0};
      script.push_back(row);
   endfunction

   // Offers one input beat and runs the model when it is taken.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [31:0] a,
                            input logic [31:0] b, input bit typed,
                            input logic [31:0] typed_a, input logic [31:0] typed_b);
      int gap;
      force_pair_type forces;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.position_a <= a;
      req_bus.position_b <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (advance_link(kind, a, b, forces)) begin
         if (typed) begin
            forces.force_a = typed_a;
            forces.force_b = typed_b;
         end
         pending_forces.push_back(forces);
      end
      case (kind)
         KIND_STEP:  n_step++;
         KIND_RESET: n_reset++;
         KIND_KEEP:  n_keep++;
         default:    n_unused++;
      endcase
   endtask

   // Waits until every force beat is back and the pipe has drained.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the queued registers back to back once the block is idle.
   task automatic write_batch();
      wait_idle();
      foreach (reg_batch[i]) begin
         @(negedge clock);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {reg_batch[i].idx, 2'b00};
         csr_pwdata  <= reg_batch[i].value;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         case (reg_batch[i].idx)
            REG_STIFFNESS:    cfg_stiffness    = reg_batch[i].value;
            REG_LINK_DAMPING: cfg_link_damping = reg_batch[i].value;
            REG_MASS_DAMPING: cfg_mass_damping = reg_batch[i].value;
            REG_REST_LENGTH:  cfg_rest_length  = reg_batch[i].value;
            REG_MIN_LENGTH:   cfg_min_length   = reg_batch[i].value[30:0];
            REG_MAX_LENGTH:   cfg_max_length   = reg_batch[i].value[30:0];
            default: ;
         endcase
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      reg_batch.delete();
      n_settings++;
   endtask

   // Force channel ready: random stalls, plus one long hold-off on request.
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (steady || $urandom_range(0, 99) < 70) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // Checks each force beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_forces.size() == 0) begin
            errors++;
            $display("%0t: force beat with none expected, force_a %h force_b %h",
                     $time, rsp_bus.force_a, rsp_bus.force_b);
         end else begin
            due = pending_forces.pop_front();
            beats_checked++;
            if (rsp_bus.force_a !== due.force_a) begin
               errors++;
               $display("%0t: force_a expected %h, got %h", $time, due.force_a,
                        rsp_bus.force_a);
            end
            if (rsp_bus.force_b !== due.force_b) begin
               errors++;
               $display("%0t: force_b expected %h, got %h", $time, due.force_b,
                        rsp_bus.force_b);
            end
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("spring_damper_link_force_top: mismatch");
      $finish;
   end

   initial begin
      longint limit_default;
      logic [KIND_W-1:0] kind;
      logic [31:0] a, b;
      int counted;

      // Known values on every input from time zero.
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_STEP;
      req_bus.position_a = '0;
      req_bus.position_b = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      errors = 0;
      beats_checked = 0;
      n_step = 0; n_reset = 0; n_keep = 0; n_unused = 0; n_settings = 0;
      steady = 1'b0;
      hold_off_req = 1'b0;
      walk_a = '0;
      walk_b = '0;

      // Model state after reset; the default upper limit saturates to 31 bits.
      limit_default = longint'(LENGTH_LIMIT_UNITS) << FRAC_BITS;
      if (limit_default > SAT_MAX) limit_default = SAT_MAX;
      cfg_stiffness    = '0;
      cfg_link_damping = '0;
      cfg_mass_damping = '0;
      cfg_rest_length  = '0;
      cfg_min_length   = '0;
      cfg_max_length   = limit_default[30:0];
      last_distance    = 0;
      last_position_a  = 0;
      last_position_b  = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Scripted corner cases. With all constants zero after reset, forces are zero.
      add_typed(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      add_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      // Unit stiffness: a 10.0 stretch gives a 10.0 pull, sign set by direction.
      add_csr(REG_STIFFNESS, 32'h0001_0000);
      add_item(KIND_RESET, 32'h0000_0000, 32'h0000_0000);
      add_typed(32'h0000_0000, 32'h000A_0000, 32'h000A_0000, 32'hFFF6_0000);
      add_typed(32'h000A_0000, 32'h0000_0000, 32'hFFF6_0000, 32'h000A_0000);
      // Largest stiffness over the whole range saturates the link force.
      add_csr(REG_STIFFNESS, 32'h7FFF_FFFF);
      add_csr(REG_MAX_LENGTH, 32'h7FFF_FFFF);
      add_typed(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
      add_typed(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
      // Mixed constants and a window of [0, 1000.0].
      add_csr(REG_STIFFNESS, 32'hFFFE_0000);
      add_csr(REG_LINK_DAMPING, 32'h0000_8000);
      add_csr(REG_MASS_DAMPING, 32'hFFFF_0000);
      add_csr(REG_REST_LENGTH, 32'h0005_0000);
      add_csr(REG_MIN_LENGTH, 32'h0000_0000);
      add_csr(REG_MAX_LENGTH, 32'h03E8_0000);
      add_item(KIND_KEEP, 32'h0003_0000, 32'h8000_0000);
      add_item(KIND_STEP, 32'h0003_0000, 32'h0003_0000);
      add_item(KIND_STEP, 32'h0000_0000, 32'h07D0_0000);
      add_item(KIND_STEP, 32'hFFF9_0000, 32'hFFFF_0000);
      add_item(KIND_STEP, 32'hFFFF_0000, 32'hFFF9_0000);
      add_item(KIND_UNUSED, 32'h1234_5678, 32'hEDCB_A987);
      add_item(KIND_STEP, 32'h0000_0000, 32'h0000_0001);
      // A distance below the lower limit is gated but still remembered.
      add_csr(REG_MIN_LENGTH, 32'h0002_0000);
      add_item(KIND_STEP, 32'h0000_0000, 32'h0001_0000);
      add_item(KIND_RESET, 32'h5555_5555, 32'hAAAA_AAAA);
      add_item(KIND_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
      // Most negative and most positive constants.
      add_csr(REG_STIFFNESS, 32'h8000_0000);
      add_csr(REG_LINK_DAMPING, 32'h8000_0000);
      add_csr(REG_MASS_DAMPING, 32'h7FFF_FFFF);
      add_csr(REG_REST_LENGTH, 32'h8000_0000);
      add_csr(REG_MIN_LENGTH, 32'h0000_0000);
      add_csr(REG_MAX_LENGTH, 32'h7FFF_FFFF);
      add_item(KIND_STEP, 32'h8000_0000, 32'h0000_0000);
      add_item(KIND_STEP, 32'h0000_0000, 32'h8000_0000);
      add_item(KIND_KEEP, 32'hFFFF_FFFF, 32'h0000_0000);
      add_item(KIND_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_csr(REG_REST_LENGTH, 32'h7FFF_FFFF);
      add_item(KIND_STEP, 32'h0000_0000, 32'h0000_0000);

      foreach (script[i]) begin
         if (script[i].op == ROW_CSR) begin
            reg_batch.push_back('{script[i].reg_idx, script[i].a});
         end else begin
            if (reg_batch.size() != 0) write_batch();
            send_item(script[i].kind, script[i].a, script[i].b, script[i].typed,
                      script[i].force_a, script[i].force_b);
         end
      end

      // Random phases, each under a fresh register setting. The first runs with
      // no idling; the fourth holds the force channel off while beats keep coming.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         reg_batch.push_back('{REG_STIFFNESS, pick_coeff()});
         reg_batch.push_back('{REG_LINK_DAMPING, pick_coeff()});
         reg_batch.push_back('{REG_MASS_DAMPING, pick_coeff()});
         reg_batch.push_back('{REG_REST_LENGTH, ($urandom_range(0, 3) == 0) ?
                               32'($urandom) : 32'($urandom_range(0, 200 << 16))});
         reg_batch.push_back('{REG_MIN_LENGTH, ($urandom_range(0, 3) == 0) ?
                               32'($urandom & 32'h7FFF_FFFF) :
                               32'($urandom_range(0, 20 << 16))});
         reg_batch.push_back('{REG_MAX_LENGTH, ($urandom_range(0, 3) == 0) ?
                               32'h7FFF_FFFF :
                               32'($urandom_range(100 << 16, 2000 << 16))});
         write_batch();
         steady = (phase == 0) || (phase == 3);
         if (phase == 3) hold_off_req = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            kind = pick_kind();
            a = next_position(walk_a);
            b = next_position(walk_b);
            send_item(kind, a, b, 1'b0, 32'h0, 32'h0);
            if (kind != KIND_UNUSED) counted++;
         end
         steady = 1'b0;
      end

      // Drain, then let the pipe run empty a while longer.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d step, %0d full reset, %0d keep reset and %0d unused beats",
               n_step, n_reset, n_keep, n_unused);
      $display("under %0d register settings; %0d force beats checked in %0d cycles.",
               n_settings, beats_checked, cycle_count);
      if (errors == 0) begin
         $display("spring_damper_link_force_top: match");
      end else begin
         $display("spring_damper_link_force_top: mismatch");
      end
      $finish;
   end

endmodule
